FILE: hw/rtl/dynamic_brake_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Dynamic brake sequencer assertion macros
// Shorthand for the concurrent checks of the sequencer, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_BRAKE_SEQUENCER_UNIT_ASSERT_SVH
`define DYNAMIC_BRAKE_SEQUENCER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dynamic brake sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define DBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dynamic brake sequencer check failed");

`endif

FILE: hw/rtl/dbs_pkg.sv
// ----------------------------------------------------------------------------
// Dynamic brake sequencer package
// Word types, step codes, stop modes and register addresses.
// ----------------------------------------------------------------------------
package dbs_pkg;

    localparam int unsigned SPEED_W = 16;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [SPEED_W-1:0] RATED_SPEED_INIT  = 16'd3000;

    localparam logic REG_PUMP_CHECK = 1'b0;
    localparam logic REG_RATED      = 1'b1;

    localparam logic [1:0] MODE_FREE       = 2'd0;
    localparam logic [1:0] MODE_BRAKE_FREE = 2'd1;
    localparam logic [1:0] MODE_BRAKE_HOLD = 2'd2;

    typedef enum logic [2:0] {
        STEP_IDLE    = 3'd0,
        STEP_WAIT    = 3'd1,
        STEP_READY   = 3'd2,
        STEP_PUMP    = 3'd3,
        STEP_RUN     = 3'd4,
        STEP_STOPPING = 3'd5,
        STEP_HOLD    = 3'd6
    } step_t;

    typedef struct packed {
        logic [1:0]         stop_mode;
        logic               encoder_bad;
        logic               motor_stopped;
        logic               brake_release_request;
        logic               travel_release_request;
        logic [SPEED_W-1:0] motor_speed;
        logic               pump_done;
    } tick_word_t;

    typedef struct packed {
        logic       brake_on;
        logic       pump_request;
        logic       base_enable;
        logic       drive_request;
        logic       pump_warning;
        logic [2:0] sequence_step;
    } result_word_t;

endpackage

FILE: hw/rtl/dynamic_brake_sequencer_unit.sv
// Path: an accepted word goes through the input register, then the result register.
// Throughput: one word per cycle while results drain; the step register is updated
// as the word leaves the input register, so the next word sees the updated step.
// Reset: rst_n clears the step to 0, all flags, pump checking, and sets rated speed
// to 3000; the input and result stages come out of reset empty.
// ----------------------------------------------------------------------------
// Dynamic brake sequencer unit
// Servo drive dynamic brake, charge pump and base enable sequencer, one scan
// tick per word, with an APB-style register port.
// ----------------------------------------------------------------------------
`include "dynamic_brake_sequencer_unit_assert.svh"

module dynamic_brake_sequencer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick_valid,
    output logic                       tick_ready,
    input  dbs_pkg::tick_word_t        tick_word,
    output logic                       result_valid,
    input  logic                       result_ready,
    output dbs_pkg::result_word_t      result_word,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dbs_pkg::ADDR_W-1:0] paddr,
    input  logic [dbs_pkg::DATA_W-1:0] pwdata,
    output logic [dbs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import dbs_pkg::*;

    logic               pump_check_reg;
    logic [SPEED_W-1:0] rated_speed_reg;

    logic               in_valid_reg;
    tick_word_t         in_word_reg;
    logic               advance;

    step_t step_reg;
    step_t step_next;
    logic  brake_reg;
    logic  brake_next;
    logic  pump_reg;
    logic  pump_next;
    logic  enable_reg;
    logic  enable_next;
    logic  warning_reg;
    logic  warning_next;

    logic         out_valid_reg;
    result_word_t out_word_reg;

    logic [1:0] mode;
    logic       req;
    logic       fr_bad;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_check_reg  <= 1'b0;
            rated_speed_reg <= RATED_SPEED_INIT;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_PUMP_CHECK: pump_check_reg  <= pwdata[0];
                REG_RATED:      rated_speed_reg <= pwdata[SPEED_W-1:0];
                default:        pump_check_reg  <= pump_check_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PUMP_CHECK: prdata = {{(DATA_W-1){1'b0}}, pump_check_reg};
            REG_RATED:      prdata = {{(DATA_W-SPEED_W){1'b0}}, rated_speed_reg};
            default:        prdata = '0;
        endcase
    end

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign tick_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_ready)
        begin
            in_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_ready && tick_valid)
        begin
            in_word_reg <= tick_word;
        end
    end

    assign mode   = in_word_reg.stop_mode;
    assign req    = in_word_reg.brake_release_request && in_word_reg.travel_release_request;
    assign fr_bad = (mode == MODE_BRAKE_FREE) && in_word_reg.encoder_bad;

    always_comb
    begin
        step_next    = step_reg;
        brake_next   = brake_reg;
        pump_next    = pump_reg;
        enable_next  = enable_reg;
        warning_next = warning_reg;
        unique case (step_reg)
            STEP_IDLE:
            begin
                pump_next   = 1'b0;
                enable_next = 1'b0;
                if (mode == MODE_FREE)
                begin
                    brake_next = 1'b0;
                    step_next  = STEP_WAIT;
                end
                else if (mode == MODE_BRAKE_FREE)
                begin
                    brake_next = in_word_reg.encoder_bad;
                    step_next  = STEP_WAIT;
                end
                else
                begin
                    brake_next = 1'b1;
                    step_next  = STEP_HOLD;
                end
            end
            STEP_WAIT:
            begin
                if (fr_bad)
                begin
                    brake_next = 1'b1;
                    pump_next  = 1'b0;
                end
                else if (mode == MODE_FREE || in_word_reg.motor_stopped)
                begin
                    brake_next = 1'b0;
                    pump_next  = 1'b0;
                    step_next  = STEP_READY;
                end
            end
            STEP_READY:
            begin
                if (mode == MODE_BRAKE_HOLD)
                begin
                    brake_next = 1'b1;
                    step_next  = STEP_HOLD;
                end
                else if (req)
                begin
                    if (!pump_check_reg)
                    begin
                        pump_next = 1'b1;
                        step_next = STEP_PUMP;
                    end
                    else if (in_word_reg.motor_speed > rated_speed_reg)
                    begin
                        warning_next = 1'b1;
                    end
                    else
                    begin
                        warning_next = 1'b0;
                        pump_next    = 1'b1;
                        step_next    = STEP_PUMP;
                    end
                end
                else
                begin
                    warning_next = 1'b0;
                    if (fr_bad)
                    begin
                        step_next = STEP_WAIT;
                    end
                end
            end
            STEP_PUMP:
            begin
                if (!req)
                begin
                    pump_next = 1'b0;
                    step_next = STEP_IDLE;
                end
                else if (in_word_reg.pump_done)
                begin
                    pump_next   = 1'b0;
                    enable_next = 1'b1;
                    step_next   = STEP_RUN;
                end
            end
            STEP_RUN:
            begin
                if (!req)
                begin
                    enable_next = 1'b0;
                    if (mode == MODE_FREE)
                    begin
                        brake_next = 1'b0;
                        step_next  = STEP_READY;
                    end
                    else if (mode == MODE_BRAKE_FREE && !in_word_reg.encoder_bad
                             && in_word_reg.motor_stopped)
                    begin
                        brake_next = 1'b0;
                        step_next  = STEP_WAIT;
                    end
                    else
                    begin
                        step_next = STEP_STOPPING;
                    end
                end
            end
            STEP_STOPPING:
            begin
                if (mode == MODE_BRAKE_FREE)
                begin
                    if (in_word_reg.encoder_bad)
                    begin
                        brake_next = 1'b1;
                    end
                    else
                    begin
                        brake_next = !in_word_reg.motor_stopped;
                        step_next  = STEP_WAIT;
                    end
                end
                else if (mode == MODE_FREE)
                begin
                    brake_next = 1'b0;
                    step_next  = STEP_WAIT;
                end
                else
                begin
                    brake_next = 1'b1;
                    step_next  = STEP_HOLD;
                end
            end
            STEP_HOLD:
            begin
                if ((!in_word_reg.encoder_bad && in_word_reg.motor_stopped && req)
                    || mode == MODE_FREE || mode == MODE_BRAKE_FREE)
                begin
                    brake_next = 1'b0;
                    step_next  = STEP_READY;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_IDLE;
            brake_reg   <= 1'b0;
            pump_reg    <= 1'b0;
            enable_reg  <= 1'b0;
            warning_reg <= 1'b0;
        end
        else if (advance)
        begin
            step_reg    <= step_next;
            brake_reg   <= brake_next;
            pump_reg    <= pump_next;
            enable_reg  <= enable_next;
            warning_reg <= warning_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg.brake_on      <= brake_next;
            out_word_reg.pump_request  <= pump_next;
            out_word_reg.base_enable   <= enable_next;
            out_word_reg.drive_request <= req;
            out_word_reg.pump_warning  <= warning_next;
            out_word_reg.sequence_step <= step_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    `DBS_ASSERT_NEXT(a_advance_fills_result, advance, result_valid)
    `DBS_ASSERT_SAME(a_enable_only_running, enable_reg, step_reg == STEP_RUN)
    `DBS_ASSERT_SAME(a_pump_only_precharge, pump_reg, step_reg == STEP_PUMP)
    `DBS_ASSERT_SAME(a_stall_needs_word, !tick_ready, in_valid_reg && out_valid_reg)

endmodule

FILE: dv/dynamic_brake_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dynamic brake sequencer unit testbench
// Drives scan tick words through the valid/ready input, predicts every result
// word with a cycle-free copy of the sequencer, and checks each result field
// by field. Covers directed step walks, register settings at their extremes,
// random idling on both sides, a long result stall and a final steady stream.
// ----------------------------------------------------------------------------
module dynamic_brake_sequencer_unit_tb;

    import dbs_pkg::*;

    localparam logic [1:0] MODE_OTHER = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_PUMP_CHECK = {REG_PUMP_CHECK, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RATED      = {REG_RATED, 2'b00};
    localparam int DRAIN_CYCLES = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TICK_W = $bits(tick_word_t);

    logic               clk;
    logic               rst_n;
    logic               tick_valid;
    logic               tick_ready;
    tick_word_t         tick_word;
    logic               result_valid;
    logic               result_ready;
    result_word_t       result_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    step_t              seq_step = STEP_IDLE;
    logic               seq_brake = 1'b0;
    logic               seq_pump = 1'b0;
    logic               seq_enable = 1'b0;
    logic               seq_warning = 1'b0;
    logic               cfg_pump_check = 1'b0;
    logic [SPEED_W-1:0] cfg_rated_speed = RATED_SPEED_INIT;

    result_word_t       expected_results[$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 result_hold_cycles = 0;
    bit                 quiet = 1'b0;

    dynamic_brake_sequencer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick_word    (tick_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic result_word_t sequencer_next(input tick_word_t w);
        logic         req;
        logic         free_bad;
        result_word_t r;
        req = w.brake_release_request & w.travel_release_request;
        free_bad = (w.stop_mode == MODE_BRAKE_FREE) && w.encoder_bad;
        case (seq_step)
            STEP_IDLE:
            begin
                seq_pump = 1'b0;
                seq_enable = 1'b0;
                if (w.stop_mode == MODE_FREE)
                begin
                    seq_brake = 1'b0;
                    seq_step = STEP_WAIT;
                end
                else if (w.stop_mode == MODE_BRAKE_FREE)
                begin
                    seq_brake = w.encoder_bad;
                    seq_step = STEP_WAIT;
                end
                else
                begin
                    seq_brake = 1'b1;
                    seq_step = STEP_HOLD;
                end
            end
            STEP_WAIT:
            begin
                if (free_bad)
                begin
                    seq_brake = 1'b1;
                    seq_pump = 1'b0;
                end
                else if (w.stop_mode == MODE_FREE || w.motor_stopped)
                begin
                    seq_brake = 1'b0;
                    seq_pump = 1'b0;
                    seq_step = STEP_READY;
                end
            end
            STEP_READY:
            begin
                if (w.stop_mode == MODE_BRAKE_HOLD)
                begin
                    seq_brake = 1'b1;
                    seq_step = STEP_HOLD;
                end
                else if (req)
                begin
                    if (!cfg_pump_check)
                    begin
                        seq_pump = 1'b1;
                        seq_step = STEP_PUMP;
                    end
                    else if (w.motor_speed > cfg_rated_speed)
                    begin
                        seq_warning = 1'b1;
                    end
                    else
                    begin
                        seq_warning = 1'b0;
                        seq_pump = 1'b1;
                        seq_step = STEP_PUMP;
                    end
                end
                else
                begin
                    seq_warning = 1'b0;
                    if (free_bad)
                        seq_step = STEP_WAIT;
                end
            end
            STEP_PUMP:
            begin
                if (!req)
                begin
                    seq_pump = 1'b0;
                    seq_step = STEP_IDLE;
                end
                else if (w.pump_done)
                begin
                    seq_pump = 1'b0;
                    seq_enable = 1'b1;
                    seq_step = STEP_RUN;
                end
            end
            STEP_RUN:
            begin
                if (!req)
                begin
                    seq_enable = 1'b0;
                    if (w.stop_mode == MODE_FREE)
                    begin
                        seq_brake = 1'b0;
                        seq_step = STEP_READY;
                    end
                    else if (w.stop_mode == MODE_BRAKE_FREE && !w.encoder_bad
                             && w.motor_stopped)
                    begin
                        seq_brake = 1'b0;
                        seq_step = STEP_WAIT;
                    end
                    else
                    begin
                        seq_step = STEP_STOPPING;
                    end
                end
            end
            STEP_STOPPING:
            begin
                if (w.stop_mode == MODE_BRAKE_FREE)
                begin
                    if (w.encoder_bad)
                    begin
                        seq_brake = 1'b1;
                    end
                    else
                    begin
                        seq_brake = !w.motor_stopped;
                        seq_step = STEP_WAIT;
                    end
                end
                else if (w.stop_mode == MODE_FREE)
                begin
                    seq_brake = 1'b0;
                    seq_step = STEP_WAIT;
                end
                else
                begin
                    seq_brake = 1'b1;
                    seq_step = STEP_HOLD;
                end
            end
            STEP_HOLD:
            begin
                if ((!w.encoder_bad && w.motor_stopped && req)
                    || w.stop_mode == MODE_FREE || w.stop_mode == MODE_BRAKE_FREE)
                begin
                    seq_brake = 1'b0;
                    seq_step = STEP_READY;
                end
            end
            default: ;
        endcase
        r.brake_on = seq_brake;
        r.pump_request = seq_pump;
        r.base_enable = seq_enable;
        r.drive_request = req;
        r.pump_warning = seq_warning;
        r.sequence_step = seq_step;
        return r;
    endfunction

    function automatic tick_word_t make_tick(input logic [1:0] mode, input logic enc_bad,
                                             input logic stopped, input logic brake_req,
                                             input logic travel_req,
                                             input logic [SPEED_W-1:0] speed,
                                             input logic done);
        tick_word_t w;
        w.stop_mode = mode;
        w.encoder_bad = enc_bad;
        w.motor_stopped = stopped;
        w.brake_release_request = brake_req;
        w.travel_release_request = travel_req;
        w.motor_speed = speed;
        w.pump_done = done;
        return w;
    endfunction

    // Most words favor progress through the sequence and speeds near the
    // rated speed; the rest are fully random.
    function automatic tick_word_t random_tick();
        tick_word_t  w;
        int unsigned pick;
        if ($urandom_range(0, 9) < 2)
        begin
            w = tick_word_t'(TICK_W'($urandom));
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
            w.stop_mode = MODE_FREE;
        else if (pick < 75)
            w.stop_mode = MODE_BRAKE_FREE;
        else if (pick < 88)
            w.stop_mode = MODE_BRAKE_HOLD;
        else
            w.stop_mode = MODE_OTHER;
        w.encoder_bad = ($urandom_range(0, 5) == 0);
        w.motor_stopped = 1'($urandom_range(0, 1));
        w.brake_release_request = ($urandom_range(0, 7) != 0);
        w.travel_release_request = ($urandom_range(0, 7) != 0);
        w.pump_done = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 5))
            0: w.motor_speed = cfg_rated_speed;
            1: w.motor_speed = cfg_rated_speed + 16'd1;
            2: w.motor_speed = cfg_rated_speed - 16'd1;
            3: w.motor_speed = '0;
            4: w.motor_speed = '1;
            default: w.motor_speed = SPEED_W'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_tick(input tick_word_t w);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_word <= w;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        expected_results.push_back(sequencer_next(w));
    endtask

    task automatic end_phase();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_PUMP_CHECK)
            cfg_pump_check = data[0];
        else
            cfg_rated_speed = data[SPEED_W-1:0];
    endtask

    task automatic set_config(input logic pump_check, input logic [SPEED_W-1:0] rated);
        reg_write(ADDR_PUMP_CHECK, {31'd0, pump_check});
        reg_write(ADDR_RATED, {16'd0, rated});
    endtask

    task automatic test_directed();
        send_tick(make_tick(MODE_OTHER, 0, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_OTHER, 0, 1, 1, 1, 16'd100, 0));
        send_tick(make_tick(MODE_OTHER, 0, 0, 1, 0, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_HOLD, 0, 0, 0, 1, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_FREE, 0, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_FREE, 1, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_FREE, 1, 1, 1, 1, 16'd0, 1));
        send_tick(make_tick(MODE_BRAKE_FREE, 0, 1, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'hFFFF, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'hFFFF, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'd0, 1));
        send_tick(make_tick(MODE_BRAKE_FREE, 1, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_FREE, 1, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_FREE, 0, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'd0, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 0, 1, 16'd0, 0));
        send_tick(make_tick(MODE_BRAKE_HOLD, 0, 0, 0, 0, 16'd0, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 0, 0, 16'd0, 0));
        end_phase();
        // With pump checking on, a speed one above rated holds the sequence
        // and a speed equal to rated lets it through.
        set_config(1'b1, 16'd3000);
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'd3001, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'd3000, 0));
        send_tick(make_tick(MODE_FREE, 0, 0, 1, 1, 16'd3000, 1));
        send_tick(make_tick(MODE_FREE, 0, 0, 0, 0, 16'd0, 0));
        end_phase();
    endtask

    task automatic test_config_sweep();
        logic [SPEED_W-1:0] rated;
        for (int i = 0; i < 6; i++)
        begin
            case (i)
                0, 1: rated = 16'd3000;
                2: rated = 16'd0;
                3: rated = 16'hFFFF;
                default: rated = SPEED_W'($urandom);
            endcase
            set_config(i != 0 && i != 5, rated);
            repeat (250) send_tick(random_tick());
            end_phase();
        end
    endtask

    task automatic test_backpressure();
        result_hold_cycles = 80;
        repeat (60) send_tick(random_tick());
        end_phase();
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        set_config(1'b1, SPEED_W'($urandom));
        repeat (250) send_tick(random_tick());
        end_phase();
    endtask

    initial
    begin
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (result_hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                repeat (result_hold_cycles) @(posedge clk);
                result_hold_cycles = 0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic check_field(input string field, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected result expected none actual %p", $time, result_word);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("brake_on", 3'(want.brake_on), 3'(result_word.brake_on));
                check_field("pump_request", 3'(want.pump_request),
                            3'(result_word.pump_request));
                check_field("base_enable", 3'(want.base_enable),
                            3'(result_word.base_enable));
                check_field("drive_request", 3'(want.drive_request),
                            3'(result_word.drive_request));
                check_field("pump_warning", 3'(want.pump_warning),
                            3'(result_word.pump_warning));
                check_field("sequence_step", want.sequence_step, result_word.sequence_step);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        tick_valid <= 1'b0;
        tick_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_steady_stream();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/dbs_pkg.sv
hw/rtl/dynamic_brake_sequencer_unit.sv
dv/dynamic_brake_sequencer_unit_tb.sv
